### hw/rtl/gmb_pkg.sv
// Shared types and constants of the grid maze path search block.
package gmb_pkg;

    localparam int CRD_W = 8;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_SEARCH = 2'd1,
        FN_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] row;
        logic [5:0] col;
        logic       wall;
        logic [5:0] end_row;
        logic [5:0] end_col;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [11:0] path_length;
        logic        on_path;
        logic        is_wall;
    } t_result;

    typedef struct packed {
        logic             vld;
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
    } t_link;

    typedef struct packed {
        logic             vld;
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic             ok;
        t_dir             dir;
        logic [CRD_W-1:0] nrow;
        logic [CRD_W-1:0] ncol;
    } t_probe;

endpackage

### hw/rtl/gmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmb_ram #(
    parameter int W = 1,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [0:D-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/gmb_dir_cell.sv
// One neighbor cell of the expansion chain: holds a grid cell and forms its neighbor.
module gmb_dir_cell #(
    parameter int          MAX_ROWS = 64,
    parameter int          MAX_COLS = 64,
    parameter gmb_pkg::t_dir DIR    = gmb_pkg::DIR_DOWN
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [6:0]      i_rows,
    input  logic [6:0]      i_cols,
    input  gmb_pkg::t_link  i_link,
    output gmb_pkg::t_probe o_probe
);
    import gmb_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int MW = (RW > CW) ? RW : CW;
    localparam int XW = ((MW > 7) ? MW : 7) + 2;

    logic          r_vld;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [XW-1:0] eff_rows;
    logic [XW-1:0] eff_cols;
    logic [RW-1:0] nrow;
    logic [CW-1:0] ncol;
    logic          ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_link.vld;
        end
        r_row <= RW'(i_link.row);
        r_col <= CW'(i_link.col);
    end

    always_comb begin
        eff_rows = (XW'(i_rows) < XW'(MAX_ROWS)) ? XW'(i_rows) : XW'(MAX_ROWS);
        eff_cols = (XW'(i_cols) < XW'(MAX_COLS)) ? XW'(i_cols) : XW'(MAX_COLS);
        nrow = r_row;
        ncol = r_col;
        ok   = 1'b0;
        case (DIR)
            DIR_DOWN: begin
                nrow = r_row + RW'(1);
                ok   = (XW'(r_row) + XW'(1)) < eff_rows;
            end
            DIR_UP: begin
                nrow = r_row - RW'(1);
                ok   = (r_row != '0);
            end
            DIR_RIGHT: begin
                ncol = r_col + CW'(1);
                ok   = (XW'(r_col) + XW'(1)) < eff_cols;
            end
            DIR_LEFT: begin
                ncol = r_col - CW'(1);
                ok   = (r_col != '0);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_probe.vld  = r_vld;
    assign o_probe.row  = CRD_W'(r_row);
    assign o_probe.col  = CRD_W'(r_col);
    assign o_probe.ok   = r_vld & ok;
    assign o_probe.dir  = DIR;
    assign o_probe.nrow = CRD_W'(nrow);
    assign o_probe.ncol = CRD_W'(ncol);
endmodule

### hw/rtl/grid_maze_bfs_path.sv
// Top level of the grid maze breadth-first shortest path search.
// Input channel: i_item is taken at a rising edge with i_start high and o_busy low.
// Result channel: o_result is valid for the one cycle in which o_done is high;
// the receiver cannot stall it, and every item gives exactly one result.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 rows in use, 1
// columns in use); the user must write only while the block is idle (not enforced).
// Load items write a wall bit and answer in the next cycle; query items read a
// cell's path mark and wall bit and answer in the next cycle; both run at one
// item per cycle with o_busy low.
// A search item raises o_busy. It first sweeps the visited and path stores, one
// entry per cycle over all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (4096 at 64x64),
// then seeds the queue with the start cell if start and end lie in the area in use.
// The wavefront walk per dequeued cell runs a pop, a queue read, the chain of four
// direction cells (one neighbor each), and then a check of the last neighbor against
// the registered wall and visited reads. A dequeued end cell goes from the queue read
// straight to the path trace, which alternates a trace and a step state per step
// back to the start cell, and the result follows in the next cycle.
// After reset o_busy stays high for one sweep over all entries that clears
// the wall, visited and path stores.
module grid_maze_bfs_path #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  gmb_pkg::t_item   i_item,
    output logic             o_done,
    output gmb_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [6:0]       i_cfg_data
);
    import gmb_pkg::*;

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int AW   = RW + CW;
    localparam int DEP  = 1 << AW;
    localparam int QD   = MAX_ROWS * MAX_COLS;
    localparam int QAW  = $clog2(QD);
    localparam int PW   = $clog2(QD + 1);
    localparam int MW   = (RW > CW) ? RW : CW;
    localparam int XW   = ((MW > 7) ? MW : 7) + 2;
    localparam int NCEL = 4;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_SEED   = 8'b0000_0100,
        ST_POP    = 8'b0000_1000,
        ST_HEAD   = 8'b0001_0000,
        ST_EXPAND = 8'b0010_0000,
        ST_TRACE  = 8'b0100_0000,
        ST_STEP   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic          vld;
        logic [AW-1:0] addr;
        t_dir          dir;
    } t_pend;

    t_state        r_state;
    logic          r_init;
    logic [AW-1:0] r_clr;
    logic [6:0]    r_rows;
    logic [6:0]    r_cols;
    logic [AW-1:0] r_start;
    logic [AW-1:0] r_goal;
    logic          r_ok_area;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [11:0]   r_steps;
    logic          r_done;
    t_result       r_res;
    logic          r_qpend;
    logic          r_qin;
    t_pend         r_pend;

    logic          acc;
    logic          item_in;
    logic          s_area;
    logic [XW-1:0] eff_rows;
    logic [XW-1:0] eff_cols;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] cur_addr;

    logic          wall_we, vis_we, path_we, came_we, q_we;
    logic [AW-1:0] wall_wa, vis_wa, path_wa, came_wa, wall_ra;
    logic          wall_wd, vis_wd, path_wd;
    logic [AW-1:0] q_wd, q_rd;
    logic [QAW-1:0] q_wa;
    logic          wall_rd, vis_rd, path_rd;
    logic [1:0]    came_rd;
    logic          dec;

    t_link  link [0:NCEL-1];
    t_probe probe [0:NCEL-1];
    t_probe act;
    logic [NCEL-1:0] pvld;
    logic [AW-1:0]   act_addr;

    assign acc = i_start & ~o_busy;
    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        eff_rows  = (XW'(r_rows) < XW'(MAX_ROWS)) ? XW'(r_rows) : XW'(MAX_ROWS);
        eff_cols  = (XW'(r_cols) < XW'(MAX_COLS)) ? XW'(r_cols) : XW'(MAX_COLS);
        item_in   = (XW'(i_item.row) < XW'(MAX_ROWS)) && (XW'(i_item.col) < XW'(MAX_COLS));
        s_area    = (XW'(i_item.row) < eff_rows) && (XW'(i_item.col) < eff_cols)
                 && (XW'(i_item.end_row) < eff_rows) && (XW'(i_item.end_col) < eff_cols);
        item_addr = {RW'(i_item.row), CW'(i_item.col)};
        cur_addr  = {r_cur_row, r_cur_col};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    assign link[0].vld = r_state[4] && (q_rd != r_goal);
    assign link[0].row = CRD_W'(q_rd[AW-1:CW]);
    assign link[0].col = CRD_W'(q_rd[CW-1:0]);

    for (genvar k = 0; k < NCEL; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign link[k].vld = probe[k-1].vld;
            assign link[k].row = probe[k-1].row;
            assign link[k].col = probe[k-1].col;
        end
        gmb_dir_cell #(
            .MAX_ROWS (MAX_ROWS),
            .MAX_COLS (MAX_COLS),
            .DIR      (t_dir'(k))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rows  (r_rows),
            .i_cols  (r_cols),
            .i_link  (link[k]),
            .o_probe (probe[k])
        );
        assign pvld[k] = probe[k].vld;
    end

    always_comb begin
        act = probe[0];
        for (int k = 1; k < NCEL; k++) begin
            if (probe[k].vld) begin
                act = probe[k];
            end
        end
        act_addr = {RW'(act.nrow), CW'(act.ncol)};
    end

    assign dec = r_pend.vld & ~wall_rd & ~vis_rd;

    always_comb begin
        wall_we = 1'b0; wall_wa = item_addr; wall_wd = i_item.wall;
        vis_we  = 1'b0; vis_wa  = r_clr;     vis_wd  = 1'b0;
        path_we = 1'b0; path_wa = r_clr;     path_wd = 1'b0;
        came_we = dec;  came_wa = r_pend.addr;
        q_we    = dec;  q_wa    = r_tail[QAW-1:0]; q_wd = r_pend.addr;
        wall_ra = r_state[0] ? item_addr : act_addr;
        case (r_state)
            ST_IDLE: begin
                wall_we = acc && (i_item.func == FN_LOAD) && item_in;
            end
            ST_CLEAR: begin
                wall_we = r_init; wall_wa = r_clr; wall_wd = 1'b0;
                vis_we  = 1'b1;
                path_we = 1'b1;
            end
            ST_SEED: begin
                vis_we = 1'b1; vis_wa = r_start; vis_wd = 1'b1;
                q_we   = 1'b1; q_wa   = '0;      q_wd   = r_start;
            end
            ST_EXPAND: begin
                vis_we = dec; vis_wa = r_pend.addr; vis_wd = 1'b1;
            end
            ST_TRACE: begin
                path_we = 1'b1; path_wa = cur_addr; path_wd = 1'b1;
            end
            default: begin
                vis_we = 1'b0;
            end
        endcase
    end

    gmb_ram #(.W(1), .D(DEP)) u_wall (
        .i_clk(i_clk), .i_we(wall_we), .i_waddr(wall_wa), .i_wdata(wall_wd),
        .i_raddr(wall_ra), .o_rdata(wall_rd));
    gmb_ram #(.W(1), .D(DEP)) u_vis (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_wa), .i_wdata(vis_wd),
        .i_raddr(act_addr), .o_rdata(vis_rd));
    gmb_ram #(.W(1), .D(DEP)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_wa), .i_wdata(path_wd),
        .i_raddr(item_addr), .o_rdata(path_rd));
    gmb_ram #(.W(2), .D(DEP)) u_came (
        .i_clk(i_clk), .i_we(came_we), .i_waddr(came_wa), .i_wdata(r_pend.dir),
        .i_raddr(cur_addr), .o_rdata(came_rd));
    gmb_ram #(.W(AW), .D(QD)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(r_head[QAW-1:0]), .o_rdata(q_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_init   <= 1'b1;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_qpend  <= 1'b0;
            r_pend.vld <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_done  <= 1'b0;
            r_qpend <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_res <= '0;
                        case (i_item.func)
                            FN_SEARCH: begin
                                r_start   <= item_addr;
                                r_goal    <= {RW'(i_item.end_row), CW'(i_item.end_col)};
                                r_ok_area <= s_area;
                                r_init    <= 1'b0;
                                r_clr     <= '0;
                                r_state   <= ST_CLEAR;
                            end
                            FN_QUERY: begin
                                r_qpend <= 1'b1;
                                r_qin   <= item_in;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        if (r_init) begin
                            r_state <= ST_IDLE;
                        end else if (r_ok_area) begin
                            r_state <= ST_SEED;
                        end else begin
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_SEED: begin
                    r_head  <= '0;
                    r_tail  <= PW'(1);
                    r_state <= ST_POP;
                end
                ST_POP: begin
                    if (r_head == r_tail) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_head  <= r_head + PW'(1);
                        r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if (q_rd == r_goal) begin
                        r_cur_row <= r_goal[AW-1:CW];
                        r_cur_col <= r_goal[CW-1:0];
                        r_steps   <= '0;
                        r_state   <= ST_TRACE;
                    end else begin
                        r_state <= ST_EXPAND;
                    end
                end
                ST_EXPAND: begin
                    r_pend.vld  <= act.ok;
                    r_pend.addr <= act_addr;
                    r_pend.dir  <= act.dir;
                    if (dec) begin
                        r_tail <= r_tail + PW'(1);
                    end
                    if ((pvld == '0) && !r_pend.vld) begin
                        r_state <= ST_POP;
                    end
                end
                ST_TRACE: begin
                    if (cur_addr == r_start) begin
                        r_done            <= 1'b1;
                        r_res.found       <= 1'b1;
                        r_res.path_length <= r_steps;
                        r_state           <= ST_IDLE;
                    end else begin
                        r_state <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    case (t_dir'(came_rd))
                        DIR_DOWN:  r_cur_row <= r_cur_row - RW'(1);
                        DIR_UP:    r_cur_row <= r_cur_row + RW'(1);
                        DIR_RIGHT: r_cur_col <= r_cur_col - CW'(1);
                        DIR_LEFT:  r_cur_col <= r_cur_col + CW'(1);
                        default:   r_cur_row <= r_cur_row;
                    endcase
                    if (r_steps != '1) begin
                        r_steps <= r_steps + 12'd1;
                    end
                    r_state <= ST_TRACE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_done   = r_done | r_qpend;
        o_result = r_res;
        if (r_qpend) begin
            o_result         = '0;
            o_result.on_path = r_qin & path_rd;
            o_result.is_wall = r_qin & wall_rd;
        end
    end

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found) |-> (o_result.path_length == 12'd0))
        else $error("not-found result with nonzero length");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_item.func == FN_SEARCH)) |=> o_busy)
        else $error("search item did not raise busy");
    a_pend_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend.vld |-> (r_state == ST_EXPAND))
        else $error("pending neighbor outside expansion");
    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(pvld))
        else $error("more than one chain cell active");
endmodule
